FILE: src/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared widths, microcode encodings, program ROM and datapath types for the
// CAN bit-timing calculator.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int ClkW   = 27;
  localparam int BaudW  = 20;
  localparam int SjwW   = 8;
  localparam int KW     = 7;
  localparam int UnitW  = 26;   // 64 * (2^20-1) fits in 26 bits
  localparam int UpcW   = 4;
  localparam int ActW   = 4;
  localparam int CondW  = 4;
  localparam int CfgIdxW = 2;

  localparam logic [KW-1:0] MaxPrescaler = 7'd64;

  // floor(4*x/9) == (x*1821) >> 12 for every 8-bit x
  localparam logic [10:0] Seg2Mul   = 11'd1821;
  localparam int          Seg2Shift = 12;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLOCK_SOURCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OSC_CLOCK    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUS_CLOCK    = 2'd2;

  localparam logic [ClkW-1:0] OscClockReset = 27'd16000000;
  localparam logic [ClkW-1:0] BusClockReset = 27'd40000000;

  // datapath actions
  localparam logic [ActW-1:0] ACT_NOP    = 4'd0;
  localparam logic [ActW-1:0] ACT_INIT   = 4'd1;
  localparam logic [ActW-1:0] ACT_MUL    = 4'd2;
  localparam logic [ActW-1:0] ACT_DSTART = 4'd3;
  localparam logic [ActW-1:0] ACT_SUM    = 4'd4;
  localparam logic [ActW-1:0] ACT_SEG    = 4'd5;
  localparam logic [ActW-1:0] ACT_DEC    = 4'd6;
  localparam logic [ActW-1:0] ACT_FIN    = 4'd7;
  localparam logic [ActW-1:0] ACT_ERR    = 4'd8;

  // jump conditions
  localparam logic [CondW-1:0] CND_NEVER     = 4'd0;
  localparam logic [CondW-1:0] CND_ALWAYS    = 4'd1;
  localparam logic [CondW-1:0] CND_NO_GO     = 4'd2;
  localparam logic [CondW-1:0] CND_BAUD_ZERO = 4'd3;
  localparam logic [CondW-1:0] CND_TOO_BIG   = 4'd4;
  localparam logic [CondW-1:0] CND_DIV_BUSY  = 4'd5;
  localparam logic [CondW-1:0] CND_REM_NZ    = 4'd6;
  localparam logic [CondW-1:0] CND_K_ONE     = 4'd7;
  localparam logic [CondW-1:0] CND_OUT_FREE  = 4'd8;

  // program step addresses
  localparam logic [UpcW-1:0] S_IDLE   = 4'd0;
  localparam logic [UpcW-1:0] S_INIT   = 4'd1;
  localparam logic [UpcW-1:0] S_MUL    = 4'd2;
  localparam logic [UpcW-1:0] S_CHECK  = 4'd3;
  localparam logic [UpcW-1:0] S_DSTART = 4'd4;
  localparam logic [UpcW-1:0] S_DWAIT  = 4'd5;
  localparam logic [UpcW-1:0] S_TEST   = 4'd6;
  localparam logic [UpcW-1:0] S_SUM    = 4'd7;
  localparam logic [UpcW-1:0] S_SEG    = 4'd8;
  localparam logic [UpcW-1:0] S_NEXT   = 4'd9;
  localparam logic [UpcW-1:0] S_LOOP   = 4'd10;
  localparam logic [UpcW-1:0] S_ERR    = 4'd11;
  localparam logic [UpcW-1:0] S_ERRW   = 4'd12;
  localparam logic [UpcW-1:0] S_FIN    = 4'd13;
  localparam logic [UpcW-1:0] S_FINW   = 4'd14;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [CondW-1:0] cond;
    logic [UpcW-1:0]  tgt;
  } cw_t;

  typedef struct packed {
    logic baud_zero;
    logic too_big;
    logic div_busy;
    logic rem_nz;
    logic k_one;
  } dp_flags_t;

  typedef struct packed {
    logic       status;
    logic [5:0] prescaler;
    logic [3:0] seg1;
    logic [2:0] seg2;
    logic [1:0] jump;
  } result_t;

  function automatic cw_t ucode_rom(input logic [UpcW-1:0] addr);
    cw_t cw;
    begin
      case (addr)
        S_IDLE:   cw = '{ACT_NOP,    CND_NO_GO,     S_IDLE};
        S_INIT:   cw = '{ACT_INIT,   CND_BAUD_ZERO, S_ERR};
        S_MUL:    cw = '{ACT_MUL,    CND_NEVER,     S_IDLE};
        S_CHECK:  cw = '{ACT_NOP,    CND_TOO_BIG,   S_NEXT};
        S_DSTART: cw = '{ACT_DSTART, CND_NEVER,     S_IDLE};
        S_DWAIT:  cw = '{ACT_NOP,    CND_DIV_BUSY,  S_DWAIT};
        S_TEST:   cw = '{ACT_NOP,    CND_REM_NZ,    S_NEXT};
        S_SUM:    cw = '{ACT_SUM,    CND_NEVER,     S_IDLE};
        S_SEG:    cw = '{ACT_SEG,    CND_ALWAYS,    S_FIN};
        S_NEXT:   cw = '{ACT_DEC,    CND_K_ONE,     S_ERR};
        S_LOOP:   cw = '{ACT_NOP,    CND_ALWAYS,    S_MUL};
        S_ERR:    cw = '{ACT_ERR,    CND_OUT_FREE,  S_IDLE};
        S_ERRW:   cw = '{ACT_NOP,    CND_ALWAYS,    S_ERR};
        S_FIN:    cw = '{ACT_FIN,    CND_OUT_FREE,  S_IDLE};
        S_FINW:   cw = '{ACT_NOP,    CND_ALWAYS,    S_FIN};
        default:  cw = '{ACT_NOP,    CND_ALWAYS,    S_IDLE};
      endcase
      return cw;
    end
  endfunction

endpackage

FILE: src/cbt_div.sv
// ----------------------------------------------------------------------------
// cbt_div
// Restoring divider, one quotient bit per cycle: clock / prescaled unit.
// ----------------------------------------------------------------------------
module cbt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cbt_pkg::ClkW-1:0]  dividend,
  input  logic [cbt_pkg::UnitW-1:0] divisor,
  output logic                      busy,
  output logic [cbt_pkg::ClkW-1:0]  quot,
  output logic [cbt_pkg::UnitW-1:0] rem
);
  import cbt_pkg::*;

  localparam int CntW = $clog2(ClkW);
  localparam logic [CntW-1:0] LastCnt = CntW'(ClkW - 1);

  logic                busy_r, busy_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [UnitW-1:0]    rem_r, rem_nxt;
  logic [ClkW-1:0]     quot_r, quot_nxt;
  logic [UnitW:0]      trial;
  logic [UnitW+1:0]    diff;

  assign trial = {rem_r, quot_r[ClkW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = LastCnt;
      rem_nxt  = '0;
      quot_nxt = dividend;
    end else if (busy_r) begin
      if (!diff[UnitW+1]) begin
        rem_nxt  = diff[UnitW-1:0];
        quot_nxt = {quot_r[ClkW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[UnitW-1:0];
        quot_nxt = {quot_r[ClkW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: src/cbt_dp.sv
// ----------------------------------------------------------------------------
// cbt_dp
// Datapath driven by the microcode action field: prescaler trial, product,
// fit check, division and final field arithmetic.
// ----------------------------------------------------------------------------
module cbt_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [cbt_pkg::BaudW-1:0] ld_baud,
  input  logic [cbt_pkg::SjwW-1:0]  ld_sjw,
  input  logic [cbt_pkg::ClkW-1:0]  ld_clk,
  input  logic [cbt_pkg::ActW-1:0]  act,
  output cbt_pkg::dp_flags_t        flags,
  output cbt_pkg::result_t          result
);
  import cbt_pkg::*;

  logic [BaudW-1:0] baud_r;
  logic [SjwW-1:0]  sjw_r;
  logic [ClkW-1:0]  clk_r;
  logic [KW-1:0]    k_r;
  logic [UnitW-1:0] unit_r;
  logic [7:0]       sum_r;
  logic [2:0]       seg2_r;

  logic             div_busy;
  logic [ClkW-1:0]  div_quot;
  logic [UnitW-1:0] div_rem;

  logic [KW+BaudW-1:0] unit_prod;
  logic [18:0]         seg_prod;
  logic [6:0]          t_val;
  logic [3:0]          m_val;
  logic [3:0]          seg1;
  logic [1:0]          jump;

  cbt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (act == ACT_DSTART),
    .dividend (clk_r),
    .divisor  (unit_r),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign unit_prod = k_r * baud_r;
  assign seg_prod  = sum_r * Seg2Mul;
  assign t_val     = seg_prod[18:Seg2Shift];
  assign m_val     = (t_val < 7'd8) ? t_val[3:0] : 4'd8;

  always_ff @(posedge clk) begin
    if (load) begin
      baud_r <= ld_baud;
      sjw_r  <= ld_sjw;
      clk_r  <= ld_clk;
    end
    case (act)
      ACT_INIT: k_r    <= MaxPrescaler;
      ACT_MUL:  unit_r <= unit_prod[UnitW-1:0];
      ACT_SUM:  sum_r  <= div_quot[7:0] - 8'd1;
      ACT_SEG:  seg2_r <= 3'(m_val - 4'd1);
      ACT_DEC:  k_r    <= k_r - 1'b1;
      default: ;
    endcase
  end

  assign flags.baud_zero = (baud_r == '0);
  assign flags.too_big   = ({unit_r, 3'b000} > {2'b00, clk_r});
  assign flags.div_busy  = div_busy;
  assign flags.rem_nz    = (div_rem != '0);
  assign flags.k_one     = (k_r == KW'(1));

  assign seg1 = sum_r[3:0] - {1'b0, seg2_r} - 4'd2;
  assign jump = (sjw_r < {5'b00000, seg2_r}) ? sjw_r[1:0] : seg2_r[1:0];

  always_comb begin
    if (act == ACT_ERR) begin
      result = '0;
      result.status = 1'b1;
    end else begin
      result.status    = 1'b0;
      result.prescaler = k_r[5:0] - 6'd1;
      result.seg1      = seg1;
      result.seg2      = seg2_r;
      result.jump      = jump;
    end
  end

endmodule

FILE: src/cbt_seq.sv
// ----------------------------------------------------------------------------
// cbt_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module cbt_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic                     out_free,
  input  cbt_pkg::dp_flags_t       flags,
  output logic [cbt_pkg::ActW-1:0] act,
  output logic                     idle
);
  import cbt_pkg::*;

  logic [UpcW-1:0] upc_r, upc_nxt;
  cw_t             cw;
  logic            take;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    case (cw.cond)
      CND_NEVER:     take = 1'b0;
      CND_ALWAYS:    take = 1'b1;
      CND_NO_GO:     take = !go;
      CND_BAUD_ZERO: take = flags.baud_zero;
      CND_TOO_BIG:   take = flags.too_big;
      CND_DIV_BUSY:  take = flags.div_busy;
      CND_REM_NZ:    take = flags.rem_nz;
      CND_K_ONE:     take = flags.k_one;
      CND_OUT_FREE:  take = out_free;
      default:       take = 1'b0;
    endcase
    upc_nxt = take ? cw.tgt : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign act  = cw.act;
  assign idle = (upc_r == S_IDLE);

endmodule

FILE: src/can_bit_timing_calc.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calc
// CAN bit-timing field calculator, microcoded search over the prescaler.
// ----------------------------------------------------------------------------
// One request at a time. The prescaler is tried from 64 down to 1; a trial
// whose product fails the 8x bound skips the division, and one that passes
// waits on the restoring divider, so the divider sets the pace. A zero bit
// rate goes straight to the error result. The finished result sits in an
// output register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module can_bit_timing_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cbt_pkg::ClkW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbt_pkg::BaudW-1:0]     in_baud_rate,
  input  logic [cbt_pkg::SjwW-1:0]      in_sync_jump,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [5:0]                    out_prescaler_field,
  output logic [3:0]                    out_seg1_field,
  output logic [2:0]                    out_seg2_field,
  output logic [1:0]                    out_jump_field
);
  import cbt_pkg::*;

  logic            clock_source_r;
  logic [ClkW-1:0] osc_clock_r;
  logic [ClkW-1:0] bus_clock_r;

  logic            idle;
  logic            in_acc;
  logic            out_free;
  logic            emit;
  logic [ActW-1:0] act;
  dp_flags_t       flags;
  result_t         result;
  result_t         out_r;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_source_r <= 1'b0;
      osc_clock_r    <= OscClockReset;
      bus_clock_r    <= BusClockReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_SOURCE: clock_source_r <= cfg_data[0];
        CFG_OSC_CLOCK:    osc_clock_r    <= cfg_data;
        CFG_BUS_CLOCK:    bus_clock_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = idle;
  assign in_acc   = in_valid && idle;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = ((act == ACT_FIN) || (act == ACT_ERR)) && out_free;

  cbt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .act      (act),
    .idle     (idle)
  );

  cbt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_acc),
    .ld_baud (in_baud_rate),
    .ld_sjw  (in_sync_jump),
    .ld_clk  (clock_source_r ? bus_clock_r : osc_clock_r),
    .act     (act),
    .flags   (flags),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_prescaler_field = out_r.prescaler;
  assign out_seg1_field      = out_r.seg1;
  assign out_seg2_field      = out_r.seg2;
  assign out_jump_field      = out_r.jump;

endmodule

FILE: dv/can_bit_timing_calc_chk.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calc_chk
// Watches the configuration port and both request channels of the bit-timing
// calculator, predicts the timing fields of every accepted request and
// compares each returned result in order. Hands a running error count to the
// testbench top.
// ----------------------------------------------------------------------------
module can_bit_timing_calc_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cbt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cbt_pkg::ClkW-1:0]    cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cbt_pkg::BaudW-1:0]   in_baud_rate,
  input  logic [cbt_pkg::SjwW-1:0]    in_sync_jump,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_status,
  input  logic [5:0]                  out_prescaler_field,
  input  logic [3:0]                  out_seg1_field,
  input  logic [2:0]                  out_seg2_field,
  input  logic [1:0]                  out_jump_field,
  input  logic                        end_check,
  output int                          pending_cnt,
  output int                          err_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbt_pkg::*;

  localparam int ReportLimit = 10;

  logic            use_bus_clk;
  logic [ClkW-1:0] osc_hz;
  logic [ClkW-1:0] bus_hz;
  result_t         timing_q[$];
  int              result_idx;
  bit              leftovers_checked;

  // Walk the prescaler down from the top; the first one that divides the
  // clock exactly with at least eight quanta per bit wins.
  function automatic result_t calc_bit_timing(input logic [BaudW-1:0] baud,
                                              input logic [SjwW-1:0]  sjw,
                                              input logic [ClkW-1:0]  clk_hz);
    result_t         res;
    longint unsigned unit;
    longint unsigned prescale;
    longint unsigned sum;
    longint unsigned seg2_raw;
    longint unsigned seg2;
    longint unsigned seg1;
    res        = '0;
    res.status = 1'b1;
    prescale   = 0;
    if (baud == '0) return res;
    for (int k = int'(MaxPrescaler); k > 0; k--) begin
      unit = longint'(k) * baud;
      if (prescale == 0 && unit * 8 <= clk_hz && (clk_hz % unit) == 0) prescale = k;
    end
    if (prescale == 0) return res;
    // quanta count wraps at 8 bits, so huge quotients can land on tiny sums
    sum      = (clk_hz / (prescale * baud) - 1) & 64'hFF;
    seg2_raw = (4 * sum) / 9;
    if (seg2_raw > 8) seg2_raw = 8;
    seg2 = (seg2_raw - 1) & 64'h7;
    seg1 = (sum - seg2 - 2) & 64'hF;
    res.status    = 1'b0;
    res.prescaler = 6'(prescale - 1);
    res.seg1      = 4'(seg1);
    res.seg2      = 3'(seg2);
    res.jump      = 2'((sjw < seg2) ? longint'(sjw) : seg2);
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      use_bus_clk       = 1'b0;
      osc_hz            = OscClockReset;
      bus_hz            = BusClockReset;
      result_idx        = 0;
      err_cnt           = 0;
      leftovers_checked = 1'b0;
      timing_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOCK_SOURCE: use_bus_clk = cfg_data[0];
          CFG_OSC_CLOCK:    osc_hz      = cfg_data;
          CFG_BUS_CLOCK:    bus_hz      = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_status, out_prescaler_field, out_seg1_field, out_seg2_field,
               out_jump_field};
        if (timing_q.size() == 0) begin
          if (err_cnt < ReportLimit)
            $display("%0t: result %0d with no request outstanding: %s%0b %0d %0d %0d %0d",
                     $time, result_idx, "status/brp/seg1/seg2/sjw=", got.status,
                     got.prescaler, got.seg1, got.seg2, got.jump);
          err_cnt++;
        end else begin
          want = timing_q.pop_front();
          if (got.status != want.status || got.prescaler != want.prescaler ||
              got.seg1 != want.seg1 || got.seg2 != want.seg2 ||
              got.jump != want.jump) begin
            if (err_cnt < ReportLimit) begin
              $display("%0t: result %0d mismatch: exp status=%0b brp=%0d seg1=%0d",
                       $time, result_idx, want.status, want.prescaler, want.seg1);
              $display("  exp seg2=%0d sjw=%0d, got status=%0b brp=%0d seg1=%0d",
                       want.seg2, want.jump, got.status, got.prescaler, got.seg1);
              $display("  got seg2=%0d sjw=%0d", got.seg2, got.jump);
            end
            err_cnt++;
          end
        end
        result_idx++;
      end
      if (in_valid && in_ready)
        timing_q.push_back(calc_bit_timing(in_baud_rate, in_sync_jump,
                                           use_bus_clk ? bus_hz : osc_hz));
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (timing_q.size() != 0) begin
          $display("%0t: %0d request(s) never answered", $time, timing_q.size());
          err_cnt += timing_q.size();
        end
      end
    end
    pending_cnt <= timing_q.size();
  end

endmodule

FILE: dv/can_bit_timing_calc_tb.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calc_tb
// Drives bit-rate requests into the CAN bit-timing calculator under several
// clock settings: a directed set for the corner cases, then randomized
// requests, mostly exact divisors of the active clock. Sender bursts and
// receiver stalls are random, with one long output stall; the checker
// instance does all prediction and comparison.
// ----------------------------------------------------------------------------
module can_bit_timing_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbt_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int ResetCycles  = 12;
  localparam int CycleLimit   = 4_000_000;
  localparam int LongHold     = 8000;
  localparam int SettleCycles = 40;
  localparam int unsigned MaxBaud = 1_000_000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [ClkW-1:0]     cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic [BaudW-1:0]    in_baud_rate = '0;
  logic [SjwW-1:0]     in_sync_jump = '0;
  logic                out_ready    = 1'b0;
  logic                end_check    = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic                out_status;
  logic [5:0]          out_prescaler_field;
  logic [3:0]          out_seg1_field;
  logic [2:0]          out_seg2_field;
  logic [1:0]          out_jump_field;
  int                  pending_cnt;
  int                  err_cnt;
  bit                  hold_req     = 1'b0;
  bit                  hold_done    = 1'b0;
  logic [ClkW-1:0]     active_clk;
  int                  burst_left   = 0;
  longint unsigned     cycle_cnt    = 0;

  can_bit_timing_calc u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_baud_rate        (in_baud_rate),
    .in_sync_jump        (in_sync_jump),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_prescaler_field (out_prescaler_field),
    .out_seg1_field      (out_seg1_field),
    .out_seg2_field      (out_seg2_field),
    .out_jump_field      (out_jump_field)
  );

  can_bit_timing_calc_chk u_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_baud_rate        (in_baud_rate),
    .in_sync_jump        (in_sync_jump),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_prescaler_field (out_prescaler_field),
    .out_seg1_field      (out_seg1_field),
    .out_seg2_field      (out_seg2_field),
    .out_jump_field      (out_jump_field),
    .end_check           (end_check),
    .pending_cnt         (pending_cnt),
    .err_cnt             (err_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("can_bit_timing_calc test failed");
      $finish;
    end
  end

  // Receiver: random ready runs, occasional open stretches, one long hold.
  initial begin
    int sel;
    int run;
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          out_ready <= 1'b1;
          repeat (300) @(posedge clk);
        end else begin
          out_ready <= (sel > 5);
          run = $urandom_range(1, 25);
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ClkW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_clocks(input logic src, input logic [ClkW-1:0] osc,
                            input logic [ClkW-1:0] bus);
    write_reg(CFG_CLOCK_SOURCE, ClkW'(src));
    write_reg(CFG_OSC_CLOCK, osc);
    write_reg(CFG_BUS_CLOCK, bus);
    cfg_we <= 1'b0;
    @(posedge clk);
    active_clk = src ? bus : osc;
  endtask

  // Holds the request until it is taken; returns on the accepting edge.
  task automatic send_request(input logic [BaudW-1:0] baud, input logic [SjwW-1:0] sjw);
    in_valid     <= 1'b1;
    in_baud_rate <= baud;
    in_sync_jump <= sjw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(0, 7);
      gap = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly exact divisors of the clock so the search finds a prescaler;
  // the rest are common rates, arbitrary rates and zero.
  function automatic logic [BaudW-1:0] pick_baud(input logic [ClkW-1:0] clk_hz);
    int unsigned sel;
    int unsigned q;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 20) return BaudW'($urandom_range(1, MaxBaud));
    if (sel < 35) begin
      case ($urandom_range(0, 11))
        0:       return BaudW'(1000000);
        1:       return BaudW'(800000);
        2:       return BaudW'(500000);
        3:       return BaudW'(250000);
        4:       return BaudW'(125000);
        5:       return BaudW'(100000);
        6:       return BaudW'(83333);
        7:       return BaudW'(50000);
        8:       return BaudW'(20000);
        9:       return BaudW'(10000);
        10:      return BaudW'(5000);
        default: return BaudW'(1000);
      endcase
    end
    for (int i = 0; i < 40; i++) begin
      q = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 65535) : $urandom_range(8, 2048);
      if (clk_hz % q == 0 && clk_hz / q >= 1 && clk_hz / q <= MaxBaud)
        return BaudW'(clk_hz / q);
    end
    return BaudW'(125000);
  endfunction

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(pick_baud(active_clk), SjwW'($urandom_range(0, 255)));
      pace_sender();
    end
    drain_results();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    active_clk = OscClockReset;

    // reset clock settings: zero rate, top rate, no-fit, seg2 clamp at 8
    send_request(BaudW'(0), SjwW'(255));
    send_request(BaudW'(1000000), SjwW'(0));
    send_request(BaudW'(1000000), SjwW'(255));
    send_request(BaudW'(500000), SjwW'(1));
    send_request(BaudW'(250000), SjwW'(2));
    send_request(BaudW'(125000), SjwW'(3));
    send_request(BaudW'(10000), SjwW'(255));
    send_request(BaudW'(1), SjwW'(128));
    send_request(BaudW'(999999), SjwW'(7));
    send_request(BaudW'(83333), SjwW'(4));
    drain_results();

    // 64*257*6 Hz: quanta counts wrap past 255 and leave sums of 0, 1, 2 and 5
    set_clocks(1'b0, ClkW'(98688), BusClockReset);
    send_request(BaudW'(6), SjwW'(255));
    send_request(BaudW'(3), SjwW'(0));
    send_request(BaudW'(2), SjwW'(5));
    send_request(BaudW'(1), SjwW'(1));
    send_request(BaudW'(6), SjwW'(2));
    drain_results();

    // back-to-back requests against a long output stall
    set_clocks(1'b1, OscClockReset, ClkW'(100000000));
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(pick_baud(active_clk), SjwW'($urandom_range(0, 255)));
    run_phase(38);

    set_clocks(1'b0, ClkW'(1), BusClockReset);
    write_reg(CFG_SPARE, ClkW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    run_phase(8);

    set_clocks(1'b1, ClkW'(24000000), ClkW'(1));
    run_phase(8);

    set_clocks(1'b0, ClkW'(100000000), ClkW'(80000000));
    run_phase(50);

    set_clocks(1'b0, ClkW'(48000000), ClkW'(20000000));
    run_phase(50);

    repeat (3) begin
      set_clocks(1'($urandom_range(0, 1)), ClkW'($urandom_range(1, 100000000)),
                 ClkW'($urandom_range(1, 100000000)));
      run_phase(30);
    end

    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (err_cnt == 0) begin
      $display("can_bit_timing_calc test passed");
    end else begin
      $display("can_bit_timing_calc test failed");
    end
    $finish;
  end

endmodule
